>>> hdl/antenna_pan_tilt_pointer_slew_core_macros.svh
// Assertion macros shared by the pointer RTL.
`ifndef ANTENNA_PAN_TILT_POINTER_SLEW_CORE_MACROS_SVH
`define ANTENNA_PAN_TILT_POINTER_SLEW_CORE_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define APT_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define APT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/aptp_pkg.sv
`default_nettype none
package aptp_pkg;

    localparam int unsigned ATAN_ENTRIES = 24;
    localparam int unsigned OFFSET_BITS = 21;
    localparam logic [7:0] DEG_90  = 8'd90;
    localparam logic [7:0] DEG_180 = 8'd180;
    localparam logic [15:0] NEAR_RADIUS_RESET = 16'd20;
    localparam logic [7:0] SLEW_STEP_RESET = 8'd1;
    localparam logic [17:0] GAIN_Q16 = 18'd107922;

    // Register indexes of the configuration port.
    localparam logic [0:0] REG_NEAR_RADIUS = 1'b0;
    localparam logic [0:0] REG_SLEW_STEP   = 1'b1;

    // Request codes.
    localparam logic REQ_POSITION = 1'b0;
    localparam logic REQ_TICK     = 1'b1;

    typedef struct packed {
        logic                   req_type;
        logic [OFFSET_BITS-1:0] east_offset;
        logic [OFFSET_BITS-1:0] north_offset;
        logic [15:0]            height;
    } in_item_t;

    typedef struct packed {
        logic [7:0] pan_now;
        logic [7:0] tilt_now;
        logic [7:0] pan_goal;
        logic [7:0] tilt_goal;
    } out_item_t;

    typedef struct packed {
        logic       index;
        logic [15:0] data;
    } cfg_item_t;

    // Rounded Q16 degree values of atan(2^-i).
    function automatic logic [21:0] atan_q16(input logic [4:0] i);
        logic [21:0] v;
        begin
            case (i)
                5'd0:  v = 22'd2949120;
                5'd1:  v = 22'd1740967;
                5'd2:  v = 22'd919879;
                5'd3:  v = 22'd466945;
                5'd4:  v = 22'd234379;
                5'd5:  v = 22'd117304;
                5'd6:  v = 22'd58666;
                5'd7:  v = 22'd29335;
                5'd8:  v = 22'd14668;
                5'd9:  v = 22'd7334;
                5'd10: v = 22'd3667;
                5'd11: v = 22'd1833;
                5'd12: v = 22'd917;
                5'd13: v = 22'd458;
                5'd14: v = 22'd229;
                5'd15: v = 22'd115;
                5'd16: v = 22'd57;
                5'd17: v = 22'd29;
                5'd18: v = 22'd14;
                5'd19: v = 22'd7;
                5'd20: v = 22'd4;
                5'd21: v = 22'd2;
                5'd22: v = 22'd1;
                default: v = 22'd0;
            endcase
            return v;
        end
    endfunction

    // Clamp a Q16 angle to 0..180 degrees and round half up.
    function automatic logic [7:0] round_deg(input logic signed [25:0] q);
        logic signed [25:0] c;
        logic [25:0] s;
        begin
            c = q;
            if (q < 0)
                c = '0;
            if (q > 26'sd11796480)
                c = 26'sd11796480;
            s = unsigned'(c) + 26'd32768;
            return s[23:16];
        end
    endfunction

endpackage
`default_nettype wire

>>> hdl/aptp_cordic.sv
`default_nettype none
`include "antenna_pan_tilt_pointer_slew_core_macros.svh"
// Vectoring CORDIC that runs one micro-rotation per cycle.
module aptp_cordic
    import aptp_pkg::*;
#(
    parameter int unsigned W     = 48,
    parameter int unsigned STEPS = 16
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic signed [W-1:0] x_in,
    input  wire logic signed [W-1:0] y_in,
    output logic                     done,
    output logic signed [W-1:0]      mag,
    output logic signed [25:0]       angle
);

    localparam int unsigned NSTEP = (STEPS < ATAN_ENTRIES) ? STEPS : ATAN_ENTRIES;

    logic signed [W-1:0] x_reg, y_reg;
    logic signed [25:0]  z_reg;
    logic [4:0]          i_reg;
    logic                busy_reg;
    logic                done_reg;
    logic signed [W-1:0] dx, dy;
    logic signed [25:0]  da;

    // Arithmetic shifts floor, as the rotation needs.
    always_comb
    begin
        dx = y_reg >>> i_reg;
        dy = x_reg >>> i_reg;
        da = signed'({4'd0, atan_q16(i_reg)});
    end

    // One rotation per cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            i_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                i_reg    <= '0;
                x_reg    <= x_in;
                y_reg    <= y_in;
                z_reg    <= '0;
            end
            else if (busy_reg)
            begin
                if (y_reg >= 0)
                begin
                    x_reg <= x_reg + dx;
                    y_reg <= y_reg - dy;
                    z_reg <= z_reg + da;
                end
                else
                begin
                    x_reg <= x_reg - dx;
                    y_reg <= y_reg + dy;
                    z_reg <= z_reg - da;
                end
                if (i_reg == 5'(NSTEP - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                i_reg <= i_reg + 5'd1;
            end
        end
    end

    assign done  = done_reg;
    assign mag   = x_reg;
    assign angle = z_reg;

    `APT_ASSERT_IMPL(a_done_ends_run, done_reg, !busy_reg, "done while busy")
    `APT_ASSERT_IMPL(a_step_range, busy_reg, i_reg < 5'(NSTEP), "step past end")
    `APT_ASSERT_NEXT(a_done_pulse, done_reg, !done_reg, "done held")

endmodule
`default_nettype wire

>>> hdl/antenna_pan_tilt_pointer_slew_core.sv
// Pan/tilt pointer: a position transaction computes pan and tilt targets with
// one shared vectoring CORDIC (a near test, then two runs, pan then tilt, when
// the squared distance exceeds the squared near radius, else both targets are
// set to 90 degrees); a tick transaction moves each current angle by slew_step
// toward its target. The block takes one transaction at a time; the result
// waits in an output register and the next transaction is taken once it leaves.
`default_nettype none
`include "antenna_pan_tilt_pointer_slew_core_macros.svh"
module antenna_pan_tilt_pointer_slew_core
    import aptp_pkg::*;
#(
    parameter int unsigned CORDIC_STEPS = 16
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire in_item_t  in_data,
    output logic           out_valid,
    input  wire logic      out_ready,
    output out_item_t      out_data,
    input  wire logic      cfg_valid,
    output logic           cfg_ready,
    input  wire cfg_item_t cfg_data
);

    localparam int unsigned CW = 64;
    localparam int unsigned DIST_W = 2 * OFFSET_BITS + 1;

    typedef enum logic [2:0] {S_IDLE, S_NEAR, S_PAN, S_ELEV, S_DONE} state_t;

    state_t       state_reg;
    logic [15:0]  near_reg;
    logic [7:0]   step_reg;
    logic [7:0]   pan_t_reg, tilt_t_reg, pan_c_reg, tilt_c_reg;
    logic signed [OFFSET_BITS-1:0] e_reg, n_reg;
    logic signed [15:0] h_reg;
    logic [OFFSET_BITS-1:0] ae_reg, an_reg;
    logic [2*OFFSET_BITS-1:0] ae_sq, an_sq;
    logic [DIST_W-1:0] dist2_reg;
    logic [31:0]  r2_reg;
    logic         out_valid_reg;
    logic         cstart;
    logic signed [34:0] h_gain;
    logic signed [CW-1:0] cx, cy, cmag;
    logic signed [25:0] cang;
    logic         cdone;
    logic signed [25:0] a_cl;
    logic [7:0]   pan_calc;
    logic signed [25:0] tilt_q;
    logic         rev;

    // Magnitudes of the offsets, registered at accept.
    function automatic logic [OFFSET_BITS-1:0] absv(input logic signed [OFFSET_BITS-1:0] v);
        return v[OFFSET_BITS-1] ? OFFSET_BITS'(-v) : OFFSET_BITS'(v);
    endfunction

    function automatic logic [7:0] approach(input logic [7:0] c, input logic [7:0] t,
                                           input logic [7:0] s);
        logic [7:0] r;
        begin
            r = c;
            if (c > t)
                r = (c - t > s) ? c - s : t;
            else if (c < t)
                r = (t - c > s) ? c + s : t;
            return r;
        end
    endfunction

    assign in_ready  = (state_reg == S_IDLE) && !out_valid_reg;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;

    // Squares for the near test and the scaled height.
    assign ae_sq  = ae_reg * ae_reg;
    assign an_sq  = an_reg * an_reg;
    assign h_gain = h_reg * signed'({1'b0, GAIN_Q16});

    // Operands of the shared CORDIC depend on the phase.
    always_comb
    begin
        if (state_reg == S_NEAR)
        begin
            cx = CW'(signed'({1'b0, ae_reg, 8'd0}));
            cy = CW'(signed'({1'b0, an_reg, 8'd0}));
        end
        else
        begin
            cx = cmag <<< 8;
            cy = CW'(h_gain);
        end
    end

    // Pan from the first run and tilt from the second.
    always_comb
    begin
        a_cl = cang;
        if (cang < 0)
            a_cl = '0;
        if (cang > 26'sd5898240)
            a_cl = 26'sd5898240;
        if (e_reg == '0)
            pan_calc = DEG_90;
        else if (n_reg == '0)
            pan_calc = 8'd0;
        else if (n_reg[OFFSET_BITS-1] == e_reg[OFFSET_BITS-1])
            pan_calc = round_deg(a_cl);
        else
            pan_calc = round_deg(26'sd11796480 - a_cl);
        rev = (!n_reg[OFFSET_BITS-1] && n_reg != '0)
            || (n_reg == '0 && !e_reg[OFFSET_BITS-1] && e_reg != '0);
        tilt_q = rev ? 26'sd11796480 - cang : cang;
    end

    aptp_cordic #(.W(CW), .STEPS(CORDIC_STEPS)) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cstart),
        .x_in  (cx),
        .y_in  (cy),
        .done  (cdone),
        .mag   (cmag),
        .angle (cang)
    );

    assign cstart = (state_reg == S_NEAR && (dist2_reg > DIST_W'(r2_reg)))
                 || (state_reg == S_PAN && cdone);

    // Sequencer, state and registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            near_reg      <= NEAR_RADIUS_RESET;
            step_reg      <= SLEW_STEP_RESET;
            pan_t_reg     <= DEG_90;
            tilt_t_reg    <= DEG_90;
            pan_c_reg     <= DEG_90;
            tilt_c_reg    <= DEG_90;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                if (cfg_data.index == REG_NEAR_RADIUS)
                    near_reg <= cfg_data.data;
                else
                    step_reg <= cfg_data.data[7:0];
            end
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        e_reg  <= signed'(in_data.east_offset[OFFSET_BITS-1:0]);
                        n_reg  <= signed'(in_data.north_offset[OFFSET_BITS-1:0]);
                        h_reg  <= signed'(in_data.height);
                        ae_reg <= absv(signed'(in_data.east_offset[OFFSET_BITS-1:0]));
                        an_reg <= absv(signed'(in_data.north_offset[OFFSET_BITS-1:0]));
                        r2_reg <= near_reg * near_reg;
                        if (in_data.req_type == REQ_TICK)
                        begin
                            pan_c_reg  <= approach(pan_c_reg, pan_t_reg, step_reg);
                            tilt_c_reg <= approach(tilt_c_reg, tilt_t_reg, step_reg);
                            state_reg  <= S_DONE;
                        end
                        else
                        begin
                            state_reg <= S_NEAR;
                            dist2_reg <= '0;
                        end
                    end
                end
                S_NEAR:
                begin
                    // The squared distance is formed first, then compared; a zero offset goes straight to the compare.
                    if (dist2_reg == '0 && (ae_reg != '0 || an_reg != '0))
                        dist2_reg <= {1'b0, ae_sq} + {1'b0, an_sq};
                    else if (dist2_reg > DIST_W'(r2_reg))
                        state_reg <= S_PAN;
                    else
                    begin
                        pan_t_reg  <= DEG_90;
                        tilt_t_reg <= DEG_90;
                        state_reg  <= S_DONE;
                    end
                end
                S_PAN:
                begin
                    if (cdone)
                    begin
                        pan_t_reg <= pan_calc;
                        state_reg <= S_ELEV;
                    end
                end
                S_ELEV:
                begin
                    if (cdone)
                    begin
                        tilt_t_reg <= round_deg(tilt_q);
                        state_reg  <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_data.pan_now   = pan_c_reg;
    assign out_data.tilt_now  = tilt_c_reg;
    assign out_data.pan_goal  = pan_t_reg;
    assign out_data.tilt_goal = tilt_t_reg;

    `APT_ASSERT_IMPL(a_no_accept_busy, state_reg != S_IDLE, !in_ready, "accept while busy")
    `APT_ASSERT_NEXT(a_done_gives_out, state_reg == S_DONE, out_valid, "result missing")
    `APT_ASSERT_IMPL(a_goal_range, out_valid, out_data.pan_goal <= DEG_180
                     && out_data.tilt_goal <= DEG_180, "goal out of range")

endmodule
`default_nettype wire
